// ===== sv/adlin_pkg.sv =====
// ============================================================================
// adlin_pkg
// Shared types, widths and constants of the cubic distance linearizer.
// ============================================================================
package adlin_pkg;

    localparam int FRAC_BITS       = 16;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int SAMPLE_W        = 16;

    localparam int RES_W   = 3;
    localparam int VREF_W  = 20;
    localparam int RATIO_W = 21;
    localparam int COEF_W  = 24;

    localparam int NUM_REGS   = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RESOLUTION = 3'd0,
        REG_VREF       = 3'd1,
        REG_RATIO      = 3'd2,
        REG_COEF_ZERO  = 3'd3,
        REG_COEF_ONE   = 3'd4,
        REG_COEF_TWO   = 3'd5,
        REG_COEF_THREE = 3'd6
    } cfg_reg_t;

    localparam logic [RES_W-1:0]          RESOLUTION_RST = 3'd3;
    localparam logic [VREF_W-1:0]         VREF_RST       = 20'd216268;
    localparam logic [RATIO_W-1:0]        RATIO_RST      = 21'd226397;
    localparam logic signed [COEF_W-1:0]  COEF_ZERO_RST  = -24'sd60214;
    localparam logic signed [COEF_W-1:0]  COEF_ONE_RST   = 24'sd117971;
    localparam logic signed [COEF_W-1:0]  COEF_TWO_RST   = -24'sd16724;
    localparam logic signed [COEF_W-1:0]  COEF_THREE_RST = 24'sd1081;

    localparam int               RES_CODES    = 6;
    localparam logic [RES_W-1:0] RES_MAX_CODE = 3'd5;

    // Datapath widths.
    localparam int V_W         = VREF_W + RATIO_W - FRAC_BITS;
    localparam int V2_W        = 2 * V_W - FRAC_BITS;
    localparam int V3_W        = V2_W + V_W - FRAC_BITS;
    localparam int V3_LO_W     = 21;
    localparam int V3_HI_W     = V3_W - V3_LO_W;
    localparam int V3_SPLIT_SH = V3_LO_W - FRAC_BITS;
    localparam int T1P_W       = COEF_W + V_W + 1;
    localparam int T1_W        = T1P_W - FRAC_BITS;
    localparam int T2P_W       = COEF_W + V2_W + 1;
    localparam int T2_W        = T2P_W - FRAC_BITS;
    localparam int PL_W        = COEF_W + V3_LO_W + 1;
    localparam int PH_W        = COEF_W + V3_HI_W + 1;
    localparam int T3_W        = COEF_W + V3_W + 1 - FRAC_BITS;
    localparam int S_W         = T2_W + 2;
    localparam int ACC_W       = T3_W + 1;

    localparam int                        UM_CONST_W = 11;
    localparam logic signed [UM_CONST_W-1:0] UM_PER_MM_S = 11'sd1000;
    localparam int UM_MUL_W  = ACC_W + UM_CONST_W;
    localparam int UM_RAW_W  = UM_MUL_W - FRAC_BITS;

    localparam int UM_W        = 14;
    localparam int MM_W        = 4;
    localparam int MAX_UM      = 10000;
    localparam int UM_PER_MM   = 1000;
    localparam int MM_RECIP_W  = 14;
    localparam logic [MM_RECIP_W-1:0] MM_RECIP = 14'd8389;
    localparam int MM_SHIFT    = 23;

    typedef struct packed {
        logic [RES_W-1:0]         resolution_code;
        logic [VREF_W-1:0]        vref_q16;
        logic [RATIO_W-1:0]       divider_ratio_q16;
        logic signed [COEF_W-1:0] coef_zero;
        logic signed [COEF_W-1:0] coef_one;
        logic signed [COEF_W-1:0] coef_two;
        logic signed [COEF_W-1:0] coef_three;
    } cfg_t;

    typedef struct packed {
        logic           failed;
        logic [V_W-1:0] volt;
    } volt_t;

    typedef struct packed {
        logic [UM_W-1:0] distance_micro;
        logic [MM_W-1:0] distance_milli;
        logic            read_status;
    } result_t;

    function automatic int res_bits(input int code);
        int bits;
        unique case (code)
            0:       bits = 6;
            1:       bits = 8;
            2:       bits = 10;
            3:       bits = 12;
            4:       bits = 14;
            default: bits = 16;
        endcase
        return bits;
    endfunction

    function automatic int eff_bits(input int code, input int cap);
        int bits;
        bits = res_bits(code);
        return (bits > cap) ? cap : bits;
    endfunction

    function automatic longint unsigned full_top(input int code, input int cap);
        longint unsigned one;
        one = 64'd1;
        return (one << eff_bits(code, cap)) - one;
    endfunction

endpackage

// ===== sv/adlin_if.sv =====
// ============================================================================
// adlin_if
// Request channels of the linearizer: converter samples in, distances out.
// ============================================================================
interface adlin_in_if;
    logic                            valid;
    logic                            ready;
    logic [adlin_pkg::SAMPLE_W-1:0]  raw_sample;
    logic                            adc_failed;

    modport source (output valid, output raw_sample, output adc_failed, input ready);
    modport sink   (input valid, input raw_sample, input adc_failed, output ready);
endinterface

interface adlin_out_if;
    logic                        valid;
    logic                        ready;
    logic [adlin_pkg::UM_W-1:0]  distance_micro;
    logic [adlin_pkg::MM_W-1:0]  distance_milli;
    logic                        read_status;

    modport source (output valid, output distance_micro, output distance_milli,
                    output read_status, input ready);
    modport sink   (input valid, input distance_micro, input distance_milli,
                    input read_status, output ready);
endinterface

// ===== sv/adlin_cfg.sv =====
// ============================================================================
// adlin_cfg
// Configuration register file, written through a plain write port.
// ============================================================================
module adlin_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [adlin_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [adlin_pkg::CFG_DATA_W-1:0]    cfg_data,
    output adlin_pkg::cfg_t                     cfg
);
    import adlin_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_RESOLUTION: cfg_next.resolution_code   = cfg_data[RES_W-1:0];
                REG_VREF:       cfg_next.vref_q16          = cfg_data[VREF_W-1:0];
                REG_RATIO:      cfg_next.divider_ratio_q16 = cfg_data[RATIO_W-1:0];
                REG_COEF_ZERO:  cfg_next.coef_zero         = $signed(cfg_data[COEF_W-1:0]);
                REG_COEF_ONE:   cfg_next.coef_one          = $signed(cfg_data[COEF_W-1:0]);
                REG_COEF_TWO:   cfg_next.coef_two          = $signed(cfg_data[COEF_W-1:0]);
                REG_COEF_THREE: cfg_next.coef_three        = $signed(cfg_data[COEF_W-1:0]);
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.resolution_code   <= RESOLUTION_RST;
            cfg_reg.vref_q16          <= VREF_RST;
            cfg_reg.divider_ratio_q16 <= RATIO_RST;
            cfg_reg.coef_zero         <= COEF_ZERO_RST;
            cfg_reg.coef_one          <= COEF_ONE_RST;
            cfg_reg.coef_two          <= COEF_TWO_RST;
            cfg_reg.coef_three        <= COEF_THREE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== sv/adlin_volt.sv =====
// ============================================================================
// adlin_volt
// Six-stage pipeline from raw sample to input voltage, scaled up by the divider ratio.
// ============================================================================
module adlin_volt #(
    parameter int SAMPLE_BITS = adlin_pkg::SAMPLE_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  adlin_pkg::cfg_t                 cfg,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [adlin_pkg::SAMPLE_W-1:0]  raw_sample,
    input  logic                            adc_failed,
    output logic                            out_valid,
    input  logic                            out_ready,
    output adlin_pkg::volt_t                out_data
);
    import adlin_pkg::*;

    localparam int N_STG = 6;
    localparam int XW    = SAMPLE_BITS + VREF_W;
    localparam int SH    = XW;
    localparam int RW    = SH - 5;
    localparam int XL_W  = XW / 2;
    localparam int XH_W  = XW - XL_W;
    localparam int MPL_W = XL_W + RW;
    localparam int MPH_W = XH_W + RW;
    localparam int P_W   = XW + RW;
    localparam int VU_W  = VREF_W + RATIO_W;

    localparam longint unsigned ONE_SH = 64'd1 << SH;
    localparam longint unsigned TOP_L [RES_CODES] = '{
        full_top(0, SAMPLE_BITS), full_top(1, SAMPLE_BITS), full_top(2, SAMPLE_BITS),
        full_top(3, SAMPLE_BITS), full_top(4, SAMPLE_BITS), full_top(5, SAMPLE_BITS)
    };
    localparam longint unsigned RECIP_L [RES_CODES] = '{
        ONE_SH / TOP_L[0], ONE_SH / TOP_L[1], ONE_SH / TOP_L[2],
        ONE_SH / TOP_L[3], ONE_SH / TOP_L[4], ONE_SH / TOP_L[5]
    };

    logic [N_STG-1:0] vld_reg;
    logic [N_STG-1:0] fail_reg;
    logic [N_STG-1:0] adv;

    logic [RES_W-1:0]       rsel;
    logic [SAMPLE_BITS-1:0] top;
    logic [RW-1:0]          recip;
    logic [SAMPLE_BITS-1:0] samp_c;

    logic [XW-1:0]     x0_next, x0_reg, x1_reg, x2_reg, x3_reg;
    logic [MPL_W-1:0]  pl1_next, pl1_reg;
    logic [MPH_W-1:0]  ph1_next, ph1_reg;
    logic [P_W-1:0]    p2;
    logic [VREF_W-1:0] q0_2_next, q0_2_reg, q0_3_reg;
    logic [XW-1:0]     qt3_next, qt3_reg;
    logic [XW-1:0]     r4;
    logic [VREF_W-1:0] vdiv4_next, vdiv4_reg;
    logic [VU_W-1:0]   vu5;
    logic [V_W-1:0]    volt5_next, volt5_reg;

    always_comb
    begin
        rsel   = (cfg.resolution_code > RES_MAX_CODE) ? RES_MAX_CODE : cfg.resolution_code;
        top    = SAMPLE_BITS'(TOP_L[rsel]);
        recip  = RW'(RECIP_L[rsel]);
        samp_c = (raw_sample > SAMPLE_W'(top)) ? top : SAMPLE_BITS'(raw_sample);
    end

    always_comb
    begin
        adv[N_STG-1] = !vld_reg[N_STG-1] || out_ready;
        for (int i = N_STG - 2; i >= 0; i--)
        begin
            adv[i] = !vld_reg[i] || adv[i+1];
        end
    end

    always_comb
    begin
        x0_next    = XW'(samp_c) * XW'(cfg.vref_q16);
        pl1_next   = MPL_W'(x0_reg[XL_W-1:0]) * MPL_W'(recip);
        ph1_next   = MPH_W'(x0_reg[XW-1:XL_W]) * MPH_W'(recip);
        p2         = (P_W'(ph1_reg) << XL_W) + P_W'(pl1_reg);
        q0_2_next  = p2[SH +: VREF_W];
        qt3_next   = XW'(q0_2_reg) * XW'(top);
        r4         = x3_reg - qt3_reg;
        vdiv4_next = q0_3_reg + VREF_W'(r4 >= XW'(top));
        vu5        = VU_W'(vdiv4_reg) * VU_W'(cfg.divider_ratio_q16);
        volt5_next = vu5[FRAC_BITS +: V_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int i = 1; i < N_STG; i++)
            begin
                if (adv[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            x0_reg      <= x0_next;
            fail_reg[0] <= adc_failed;
        end
        if (adv[1])
        begin
            pl1_reg     <= pl1_next;
            ph1_reg     <= ph1_next;
            x1_reg      <= x0_reg;
            fail_reg[1] <= fail_reg[0];
        end
        if (adv[2])
        begin
            q0_2_reg    <= q0_2_next;
            x2_reg      <= x1_reg;
            fail_reg[2] <= fail_reg[1];
        end
        if (adv[3])
        begin
            q0_3_reg    <= q0_2_reg;
            qt3_reg     <= qt3_next;
            x3_reg      <= x2_reg;
            fail_reg[3] <= fail_reg[2];
        end
        if (adv[4])
        begin
            vdiv4_reg   <= vdiv4_next;
            fail_reg[4] <= fail_reg[3];
        end
        if (adv[5])
        begin
            volt5_reg   <= volt5_next;
            fail_reg[5] <= fail_reg[4];
        end
    end

    assign in_ready        = adv[0];
    assign out_valid       = vld_reg[N_STG-1];
    assign out_data.failed = fail_reg[N_STG-1];
    assign out_data.volt   = volt5_reg;

endmodule

// ===== sv/adlin_poly.sv =====
// ============================================================================
// adlin_poly
// Seven-stage pipeline for the cubic, the micrometre scale and the clamp.
// ============================================================================
module adlin_poly (
    input  logic                clk,
    input  logic                rst_n,
    input  adlin_pkg::cfg_t     cfg,
    input  logic                in_valid,
    output logic                in_ready,
    input  adlin_pkg::volt_t    in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output adlin_pkg::result_t  out_data
);
    import adlin_pkg::*;

    localparam int N_STG = 7;
    localparam logic signed [UM_RAW_W-1:0] UM_CAP = UM_RAW_W'(MAX_UM);
    localparam int MM_P_W = UM_W + MM_RECIP_W;

    logic [N_STG-1:0] vld_reg;
    logic [N_STG-2:0] fail_reg;
    logic [N_STG-1:0] adv;

    logic [2*V_W-1:0]         v2_prod;
    logic [V_W-1:0]           v_0_reg;
    logic [V2_W-1:0]          v2_0_next, v2_0_reg, v2_1_reg;
    logic [V2_W+V_W-1:0]      v3_prod;
    logic [V3_W-1:0]          v3_1_next, v3_1_reg;
    logic signed [T1P_W-1:0]  t1_prod;
    logic signed [T1_W-1:0]   t1_1_next, t1_1_reg, t1_2_reg;
    logic signed [T2P_W-1:0]  t2_prod;
    logic signed [T2_W-1:0]   t2_2_next, t2_2_reg;
    logic signed [PL_W-1:0]   pl_2_next, pl_2_reg;
    logic signed [PH_W-1:0]   ph_2_next, ph_2_reg;
    logic signed [T3_W-1:0]   t3_3_next, t3_3_reg;
    logic signed [S_W-1:0]    s_3_next, s_3_reg;
    logic signed [ACC_W-1:0]  acc_4_next, acc_4_reg;
    logic signed [UM_MUL_W-1:0] um_prod;
    logic signed [UM_RAW_W-1:0] um_raw;
    logic [UM_W-1:0]          um_5_next, um_5_reg;
    logic [MM_P_W-1:0]        mm_prod;
    result_t                  res_6_next, res_6_reg;

    always_comb
    begin
        adv[N_STG-1] = !vld_reg[N_STG-1] || out_ready;
        for (int i = N_STG - 2; i >= 0; i--)
        begin
            adv[i] = !vld_reg[i] || adv[i+1];
        end
    end

    always_comb
    begin
        v2_prod   = (2*V_W)'(in_data.volt) * (2*V_W)'(in_data.volt);
        v2_0_next = v2_prod[FRAC_BITS +: V2_W];

        v3_prod   = (V2_W+V_W)'(v2_0_reg) * (V2_W+V_W)'(v_0_reg);
        v3_1_next = v3_prod[FRAC_BITS +: V3_W];
        t1_prod   = T1P_W'($signed(cfg.coef_one)) * T1P_W'($signed({1'b0, v_0_reg}));
        t1_1_next = T1_W'(t1_prod >>> FRAC_BITS);

        t2_prod   = T2P_W'($signed(cfg.coef_two)) * T2P_W'($signed({1'b0, v2_1_reg}));
        t2_2_next = T2_W'(t2_prod >>> FRAC_BITS);
        pl_2_next = PL_W'($signed(cfg.coef_three))
                  * PL_W'($signed({1'b0, v3_1_reg[V3_LO_W-1:0]}));
        ph_2_next = PH_W'($signed(cfg.coef_three))
                  * PH_W'($signed({1'b0, v3_1_reg[V3_W-1:V3_LO_W]}));

        t3_3_next = (T3_W'(ph_2_reg) <<< V3_SPLIT_SH) + T3_W'(pl_2_reg >>> FRAC_BITS);
        s_3_next  = S_W'(t1_2_reg) + S_W'(t2_2_reg) + S_W'($signed(cfg.coef_zero));

        acc_4_next = ACC_W'(t3_3_reg) + ACC_W'(s_3_reg);

        um_prod = UM_MUL_W'(acc_4_reg) * UM_MUL_W'(UM_PER_MM_S);
        um_raw  = UM_RAW_W'(um_prod >>> FRAC_BITS);
        if (um_raw < 0)
        begin
            um_5_next = '0;
        end
        else if (um_raw > UM_CAP)
        begin
            um_5_next = UM_W'(MAX_UM);
        end
        else
        begin
            um_5_next = UM_W'(um_raw);
        end

        mm_prod = MM_P_W'(um_5_reg) * MM_P_W'(MM_RECIP);
        if (fail_reg[5])
        begin
            res_6_next.distance_micro = '0;
            res_6_next.distance_milli = '0;
            res_6_next.read_status    = 1'b1;
        end
        else
        begin
            res_6_next.distance_micro = um_5_reg;
            res_6_next.distance_milli = mm_prod[MM_SHIFT +: MM_W];
            res_6_next.read_status    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int i = 1; i < N_STG; i++)
            begin
                if (adv[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            v_0_reg     <= in_data.volt;
            v2_0_reg    <= v2_0_next;
            fail_reg[0] <= in_data.failed;
        end
        if (adv[1])
        begin
            v2_1_reg    <= v2_0_reg;
            v3_1_reg    <= v3_1_next;
            t1_1_reg    <= t1_1_next;
            fail_reg[1] <= fail_reg[0];
        end
        if (adv[2])
        begin
            t1_2_reg    <= t1_1_reg;
            t2_2_reg    <= t2_2_next;
            pl_2_reg    <= pl_2_next;
            ph_2_reg    <= ph_2_next;
            fail_reg[2] <= fail_reg[1];
        end
        if (adv[3])
        begin
            t3_3_reg    <= t3_3_next;
            s_3_reg     <= s_3_next;
            fail_reg[3] <= fail_reg[2];
        end
        if (adv[4])
        begin
            acc_4_reg   <= acc_4_next;
            fail_reg[4] <= fail_reg[3];
        end
        if (adv[5])
        begin
            um_5_reg    <= um_5_next;
            fail_reg[5] <= fail_reg[4];
        end
        if (adv[6])
        begin
            res_6_reg   <= res_6_next;
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = vld_reg[N_STG-1];
    assign out_data  = res_6_reg;

endmodule

// ===== sv/adc_to_distance_cubic_linearizer.sv =====
// ============================================================================
// adc_to_distance_cubic_linearizer
// Converts raw converter samples into clamped distances through a cubic.
// ============================================================================
// The samples channel takes one request per cycle: a raw converter sample and
// its error flag. The results channel returns, in the same order, the distance
// in micrometres (0 to 10000), in whole millimetres, and a status that is set
// when the converter reported an error, in which case both distances are zero.
// The user must write configuration registers through the plain write port
// only while no request is in flight; the block itself does not enforce this.
// A request passes thirteen register stages, the first loaded at the accepting
// edge. Six stages form the voltage (sample times reference, a reciprocal
// multiply with one correction step for the full-scale division, and the
// divider ratio), and seven evaluate the cubic and the scaling.
// Throughput is one request per cycle. Each stage holds its own valid bit, so
// a stall at the results channel fills empty stages first and only then
// deasserts ready on the samples channel; nothing is dropped or repeated.
// Reset clears all valid bits and loads the documented register defaults.
// ============================================================================
module adc_to_distance_cubic_linearizer #(
    parameter int SAMPLE_BITS = adlin_pkg::SAMPLE_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [adlin_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [adlin_pkg::CFG_DATA_W-1:0]  cfg_data,
    adlin_in_if.sink                          samples,
    adlin_out_if.source                       results
);
    import adlin_pkg::*;

    cfg_t    cfg;
    logic    volt_valid;
    logic    volt_ready;
    volt_t   volt_data;
    result_t res_data;

    adlin_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    adlin_volt #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_volt (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .in_valid   (samples.valid),
        .in_ready   (samples.ready),
        .raw_sample (samples.raw_sample),
        .adc_failed (samples.adc_failed),
        .out_valid  (volt_valid),
        .out_ready  (volt_ready),
        .out_data   (volt_data)
    );

    adlin_poly u_poly (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (volt_valid),
        .in_ready  (volt_ready),
        .in_data   (volt_data),
        .out_valid (results.valid),
        .out_ready (results.ready),
        .out_data  (res_data)
    );

    assign results.distance_micro = res_data.distance_micro;
    assign results.distance_milli = res_data.distance_milli;
    assign results.read_status    = res_data.read_status;

endmodule

// ===== sv/adlin_checker.sv =====
// ============================================================================
// adlin_checker
// Port-level checks on the results channel of the linearizer.
// ============================================================================
module adlin_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        valid,
    input  logic                        ready,
    input  logic [adlin_pkg::UM_W-1:0]  distance_micro,
    input  logic [adlin_pkg::MM_W-1:0]  distance_milli,
    input  logic                        read_status
);
    import adlin_pkg::*;

    // A stalled result keeps its value until it is taken.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !ready |=> valid && $stable(distance_micro)
            && $stable(distance_milli) && $stable(read_status))
        else $error("result changed while stalled");

    // A converter error reports zero distance.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        valid && read_status |-> distance_micro == '0 && distance_milli == '0)
        else $error("nonzero distance on converter error");

    // The distance never leaves the clamp range.
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> 32'(distance_micro) <= 32'(MAX_UM))
        else $error("distance above clamp bound");

    // Millimetres are the truncated micrometres.
    a_mm: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !read_status |->
            32'(distance_milli) * 32'(UM_PER_MM) <= 32'(distance_micro)
            && 32'(distance_micro) < 32'(distance_milli) * 32'(UM_PER_MM) + 32'(UM_PER_MM))
        else $error("millimetres disagree with micrometres");

endmodule

bind adc_to_distance_cubic_linearizer adlin_checker u_adlin_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .valid          (results.valid),
    .ready          (results.ready),
    .distance_micro (results.distance_micro),
    .distance_milli (results.distance_milli),
    .read_status    (results.read_status)
);
